### hdl/m5m8_pkg.sv
package m5m8_pkg;

    // Level that both smoothing windows hold after reset.
    localparam int unsigned RESET_LEVEL = 1200;

    // Depth of the mean window. It is a power of two, so the mean is a shift.
    localparam int MEAN_TAPS  = 8;
    localparam int MEAN_SHIFT = $clog2(MEAN_TAPS);

endpackage

### hdl/m5m8_median.sv
module m5m8_median
    import m5m8_pkg::*;
#(
    parameter int TAPS  = 5,
    parameter int WIDTH = 16
) (
    input  logic [TAPS-1:0][WIDTH-1:0] window,
    output logic [WIDTH-1:0]           median
);

    localparam int CW  = $clog2(TAPS);
    localparam int MID = TAPS / 2;

    // Each entry gets a distinct rank; equal values are ordered by position,
    // so exactly one entry carries the middle rank.
    always_comb
    begin
        logic [CW-1:0] rank;
        median = '0;
        rank   = '0;
        for (int i = 0; i < TAPS; i++)
        begin
            rank = '0;
            for (int j = 0; j < TAPS; j++)
            begin
                if (j != i)
                begin
                    if ((window[j] < window[i]) || ((window[j] == window[i]) && (j < i)))
                    begin
                        rank = rank + CW'(1);
                    end
                end
            end
            if (rank == CW'(MID))
            begin
                median = median | window[i];
            end
        end
    end

endmodule

### hdl/m5m8_div.sv
module m5m8_div
    import m5m8_pkg::*;
#(
    parameter int WIDTH = 16
) (
    input  logic [WIDTH+MEAN_SHIFT-1:0] dividend,
    output logic [WIDTH-1:0]            quotient
);

    // Dividing by MEAN_TAPS drops the low MEAN_SHIFT bits of the sum.
    assign quotient = dividend[WIDTH+MEAN_SHIFT-1:MEAN_SHIFT];

endmodule

### hdl/median5_then_mean8_filter.sv
// Two-stage smoothing filter: median of the last MEDIAN_TAPS samples, then
// the truncated mean of the last MEAN_TAPS medians.
//
// Input beats arrive on s_axis (tdata carries one unsigned sample), and one
// filtered beat leaves on m_axis for every input beat, in order.
// An input beat moves through the registers in order, each step only while
// the pipeline advances: the taking edge loads the sample window, then the
// median goes into the mean line, the running sum is updated, and the output
// register that drives m_axis_tvalid loads through the divide by MEAN_TAPS,
// a plain shift. Throughput is one beat per cycle while the receiver keeps up.
//
// After reset both windows read as 1200 (cut to SAMPLE_BITS), the running sum
// matches them, and no beat is pending.
//
// When the receiver stalls, the result waits in the output register and one
// more result can land in a skid register, so the pipeline keeps taking input
// until one does; s_axis_tready drops only once the skid register is full, and
// the whole pipeline then holds until m_axis takes a beat.
module median5_then_mean8_filter
    import m5m8_pkg::*;
#(
    parameter int MEDIAN_TAPS = 5,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      s_axis_tvalid,
    output logic                                      s_axis_tready,
    input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0]  s_axis_tdata,  // sample
    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0]  m_axis_tdata   // filtered
);

    localparam int DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int CL        = MEAN_SHIFT;
    localparam int SUM_BITS  = SAMPLE_BITS + CL;
    localparam logic [SAMPLE_BITS-1:0] RESET_SAMPLE = SAMPLE_BITS'(RESET_LEVEL);
    localparam logic [SUM_BITS-1:0]    SUM_RESET    =
        SUM_BITS'(MEAN_TAPS) * SUM_BITS'(RESET_SAMPLE);

    logic adv;
    logic in_fire;

    logic [MEDIAN_TAPS-1:0][SAMPLE_BITS-1:0] win_reg;
    logic                                    win_valid_reg;
    logic [SAMPLE_BITS-1:0]                  median;

    logic [MEAN_TAPS-1:0][SAMPLE_BITS-1:0]   line_reg;
    logic [SAMPLE_BITS-1:0]                  med_reg;
    logic [SAMPLE_BITS-1:0]                  old_reg;
    logic                                    med_valid_reg;

    logic [SUM_BITS-1:0]                     sum_reg;
    logic                                    sum_valid_reg;

    logic [SAMPLE_BITS-1:0]                  quotient;

    logic                                    out_valid_reg;
    logic                                    out_valid_next;
    logic [SAMPLE_BITS-1:0]                  out_data_reg;
    logic [SAMPLE_BITS-1:0]                  out_data_next;
    logic                                    skid_valid_reg;
    logic                                    skid_valid_next;
    logic [SAMPLE_BITS-1:0]                  skid_data_reg;
    logic [SAMPLE_BITS-1:0]                  skid_data_next;
    logic                                    pop;
    logic                                    push;

    // The pipeline moves only while the skid register has room.
    assign adv           = !skid_valid_reg;
    assign s_axis_tready = adv;
    assign in_fire       = s_axis_tvalid && adv;

    // Sample window as a shift line; the median does not depend on order.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_valid_reg <= 1'b0;
            win_reg       <= {MEDIAN_TAPS{RESET_SAMPLE}};
        end
        else if (adv)
        begin
            win_valid_reg <= in_fire;
            if (in_fire)
            begin
                win_reg <= {win_reg[MEDIAN_TAPS-2:0], s_axis_tdata[SAMPLE_BITS-1:0]};
            end
        end
    end

    m5m8_median #(
        .TAPS  (MEDIAN_TAPS),
        .WIDTH (SAMPLE_BITS)
    ) u_median (
        .window (win_reg),
        .median (median)
    );

    // Mean line: the entry falling off the end is the one the sum loses.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            med_valid_reg <= 1'b0;
            line_reg      <= {MEAN_TAPS{RESET_SAMPLE}};
            med_reg       <= '0;
            old_reg       <= '0;
        end
        else if (adv)
        begin
            med_valid_reg <= win_valid_reg;
            if (win_valid_reg)
            begin
                line_reg <= {line_reg[MEAN_TAPS-2:0], median};
                med_reg  <= median;
                old_reg  <= line_reg[MEAN_TAPS-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
            sum_reg       <= SUM_RESET;
        end
        else if (adv)
        begin
            sum_valid_reg <= med_valid_reg;
            if (med_valid_reg)
            begin
                sum_reg <= sum_reg + SUM_BITS'(med_reg) - SUM_BITS'(old_reg);
            end
        end
    end

    m5m8_div #(
        .WIDTH (SAMPLE_BITS)
    ) u_div (
        .dividend (sum_reg),
        .quotient (quotient)
    );

    // Output register plus one skid entry. A beat enters the skid register
    // only when the output register is full and not being taken.
    assign pop  = out_valid_reg && m_axis_tready;
    assign push = adv && sum_valid_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                if (push)
                begin
                    out_data_next = quotient;
                end
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = quotient;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = DATA_BITS'(out_data_reg);

endmodule

### hdl/m5m8_check.sv
module m5m8_check
#(
    parameter int DATA_BITS = 16
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [DATA_BITS-1:0] m_axis_tdata
);

    // A stalled output beat stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output beat dropped while stalled");

    // A stalled output beat keeps its data.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output data changed while stalled");

    // Input back-pressure only exists while a result is waiting downstream.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result pending");

    // Input ready drops only after the receiver refused a beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready))
        else $error("input ready dropped without an output stall");

endmodule

bind median5_then_mean8_filter m5m8_check #(
    .DATA_BITS (DATA_BITS)
) u_m5m8_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
